### hdl/fts_pkg.sv
// Shared types, constants and token tables for the fixed token substituter.
// No dependencies; used by fts_front, fts_back and the top level.
package fts_pkg;

    // Held buffer sizing
    localparam int MAX_TOKEN_LEN = 8;
    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int IDX_W = $clog2(MAX_TOKEN_LEN);

    // Escape strings are at most 6 bytes long
    localparam int ESC_W = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Token head characters
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_LBR  = 8'h7B;
    localparam logic [7:0] CH_RBR  = 8'h7D;

    // Multi-byte source tokens, index 0 is the first character
    localparam logic [0:7][7:0] FROM_INF  = "infinity";
    localparam logic [0:2][7:0] FROM_DOTS = "...";

    // Replacement strings
    localparam logic [0:4][7:0] ESC_COUT  = "\\cout";
    localparam logic [0:5][7:0] ESC_INFTY = "\\infty";
    localparam logic [0:5][7:0] ESC_CDOTS = "\\cdots";
    localparam logic [0:1][7:0] ESC_LBR   = "\\{";
    localparam logic [0:1][7:0] ESC_RBR   = "\\}";

    typedef enum logic [2:0] {
        TOK_STAR,
        TOK_INF,
        TOK_DOTS,
        TOK_LBR,
        TOK_RBR
    } t_tok;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PREFIX,
        KIND_FULL
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_tok  tok;
    } t_match;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qport;

    typedef logic [MAX_TOKEN_LEN-1:0][7:0] t_pend;

    // Length of a source token
    function automatic logic [CNT_W-1:0] from_len(input t_tok tok);
        logic [CNT_W-1:0] len;
        unique case (tok)
            TOK_STAR: len = CNT_W'(1);
            TOK_INF:  len = CNT_W'(8);
            TOK_DOTS: len = CNT_W'(3);
            TOK_LBR:  len = CNT_W'(1);
            TOK_RBR:  len = CNT_W'(1);
            default:  len = CNT_W'(1);
        endcase
        return len;
    endfunction

    // Character k of a source token (zero past the end of the dots token; one-byte tokens ignore k)
    function automatic logic [7:0] from_char(input t_tok tok, input logic [IDX_W-1:0] k);
        logic [7:0] c;
        c = '0;
        unique case (tok)
            TOK_STAR: c = CH_STAR;
            TOK_INF:  if (int'(k) < 8) c = FROM_INF[k[2:0]];
            TOK_DOTS: if (int'(k) < 3) c = FROM_DOTS[k[1:0]];
            TOK_LBR:  c = CH_LBR;
            TOK_RBR:  c = CH_RBR;
            default:  c = '0;
        endcase
        return c;
    endfunction

    // Length of a replacement string
    function automatic logic [ESC_W-1:0] esc_len(input t_tok tok);
        logic [ESC_W-1:0] len;
        unique case (tok)
            TOK_STAR: len = ESC_W'(5);
            TOK_INF:  len = ESC_W'(6);
            TOK_DOTS: len = ESC_W'(6);
            TOK_LBR:  len = ESC_W'(2);
            TOK_RBR:  len = ESC_W'(2);
            default:  len = ESC_W'(2);
        endcase
        return len;
    endfunction

    // Character k of a replacement string
    function automatic logic [7:0] esc_char(input t_tok tok, input logic [ESC_W-1:0] k);
        logic [7:0] c;
        c = '0;
        unique case (tok)
            TOK_STAR: if (k < ESC_W'(5)) c = ESC_COUT[k];
            TOK_INF:  if (k < ESC_W'(6)) c = ESC_INFTY[k];
            TOK_DOTS: if (k < ESC_W'(6)) c = ESC_CDOTS[k];
            TOK_LBR:  if (k < ESC_W'(2)) c = ESC_LBR[k[0]];
            TOK_RBR:  if (k < ESC_W'(2)) c = ESC_RBR[k[0]];
            default:  c = '0;
        endcase
        return c;
    endfunction

    // Match the first n held bytes against the token table.
    // Head characters are all distinct, so the first byte picks the token.
    function automatic t_match classify(input t_pend b, input logic [CNT_W-1:0] n);
        t_match           m;
        logic [CNT_W-1:0] len;
        logic             ok;
        m.kind = KIND_NONE;
        m.tok  = TOK_STAR;
        ok     = 1'b1;
        case (b[0])
            CH_STAR: m.tok = TOK_STAR;
            CH_I:    m.tok = TOK_INF;
            CH_DOT:  m.tok = TOK_DOTS;
            CH_LBR:  m.tok = TOK_LBR;
            CH_RBR:  m.tok = TOK_RBR;
            default: ok = 1'b0;
        endcase
        len = from_len(m.tok);
        if (n == '0 || n > len) ok = 1'b0;
        for (int k = 1; k < MAX_TOKEN_LEN; k++) begin
            if (CNT_W'(k) < n && from_char(m.tok, IDX_W'(k)) != b[k]) ok = 1'b0;
        end
        if (ok) begin
            m.kind = (n == len) ? KIND_FULL : KIND_PREFIX;
        end
        return m;
    endfunction

endpackage

### hdl/fts_front.sv
// Front end: accepts input items and queues them for the back end.
// Depends on fts_pkg.
module fts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fts_pkg::t_item i_item,
    output fts_pkg::t_qport o_q,
    input  logic           i_pop
);

    fts_pkg::t_item                     r_mem [fts_pkg::QUEUE_DEPTH];
    logic [fts_pkg::QPTR_W-1:0]         r_wr_ptr;
    logic [fts_pkg::QPTR_W-1:0]         r_rd_ptr;
    logic [fts_pkg::QCNT_W-1:0]         r_count;
    logic                               push;
    logic                               pop;

    assign o_ready = (r_count < fts_pkg::QCNT_W'(fts_pkg::QUEUE_DEPTH));
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_count != '0);

    // Head of queue
    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_mem[r_rd_ptr];

    // Storage write
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/fts_back.sv
// Back end: held-byte buffer, token matcher, rescan sequencer, output register.
// Depends on fts_pkg.
module fts_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fts_pkg::t_qport i_q,
    output logic            o_pop,
    output logic            o_m_valid,
    input  logic            i_m_ready,
    output logic [7:0]      o_m_data,
    output logic            o_m_last
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_TOKEN
    } t_state;

    t_state                         r_state;
    fts_pkg::t_pend                 r_pend;
    logic [fts_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_fin;
    fts_pkg::t_tok                  r_tok;
    logic [fts_pkg::ESC_W-1:0]      r_k;
    logic                           r_out_valid;
    logic [7:0]                     r_out_data;
    logic                           r_out_last;

    fts_pkg::t_pend                 shifted;
    fts_pkg::t_match                m_cur;
    fts_pkg::t_match                m_rest;
    logic                           out_free;
    logic                           out_load;
    logic                           raw_last;
    logic                           tok_last;

    // Held bytes after dropping the first one
    assign shifted = {r_pend[fts_pkg::MAX_TOKEN_LEN-1], r_pend[fts_pkg::MAX_TOKEN_LEN-1:1]};

    // Match on the buffer now, and on the buffer after a raw pass
    assign m_cur  = fts_pkg::classify(r_pend, r_cnt);
    assign m_rest = fts_pkg::classify(shifted, r_cnt - 1'b1);

    // A raw byte ends the run if nothing is left, or what is left waits for more
    assign raw_last = (r_cnt == fts_pkg::CNT_W'(1)) ||
                      (m_rest.kind == fts_pkg::KIND_PREFIX && !r_fin);
    assign tok_last = (r_k == fts_pkg::esc_len(r_tok) - 1'b1);

    assign out_free = !r_out_valid || i_m_ready;
    assign o_pop    = (r_state == S_LOAD) && i_q.valid;

    // An output byte is loaded this cycle: a raw pass or an escape byte
    assign out_load = out_free &&
                      ((r_state == S_TOKEN) ||
                       (r_state == S_SCAN && r_cnt != '0 &&
                        m_cur.kind != fts_pkg::KIND_FULL &&
                        !(m_cur.kind == fts_pkg::KIND_PREFIX && !r_fin)));

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_last  = r_out_last;

    // Sequencer, buffer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_q.valid) begin
                        r_pend[r_cnt[fts_pkg::IDX_W-1:0]] <= i_q.item.ch;
                        r_cnt   <= r_cnt + 1'b1;
                        r_fin   <= i_q.item.fin;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == '0) begin
                        r_state <= S_LOAD;
                    end else if (m_cur.kind == fts_pkg::KIND_FULL) begin
                        r_cnt   <= '0;
                        r_tok   <= m_cur.tok;
                        r_k     <= '0;
                        r_state <= S_TOKEN;
                    end else if (m_cur.kind == fts_pkg::KIND_PREFIX && !r_fin) begin
                        r_state <= S_LOAD;
                    end else if (out_free) begin
                        // pass the first held byte unchanged and rescan the rest
                        r_out_data  <= r_pend[0];
                        r_out_last  <= raw_last;
                        r_pend      <= shifted;
                        r_cnt       <= r_cnt - 1'b1;
                        if (raw_last) r_state <= S_LOAD;
                    end
                end
                S_TOKEN: begin
                    if (out_free) begin
                        r_out_data  <= fts_pkg::esc_char(r_tok, r_k);
                        r_out_last  <= tok_last;
                        r_k         <= r_k + 1'b1;
                        if (tok_last) r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // A new byte always finds room in the held buffer
    a_room_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && i_q.valid) |-> (r_cnt < fts_pkg::CNT_W'(fts_pkg::MAX_TOKEN_LEN)))
        else $error("held buffer full on load");

    // Escape emission stays inside the string and the buffer is already cleared
    a_token_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TOKEN) |-> (r_k < fts_pkg::esc_len(r_tok) && r_cnt == '0))
        else $error("escape index out of range");

    // Scanning never starts on an empty buffer
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt != '0))
        else $error("scan with empty buffer");

endmodule

### hdl/fixed_token_substituter_core.sv
// An accepted item goes through the input queue, the held buffer and the output register;
// a token is replaced in state S_TOKEN, one escape byte per output load, and held bytes
// are flushed raw the same way. The queue takes new items while the back end is busy, until it is full;
// the rescan sequencer in the back end emits one byte per cycle at most.
// Reset (i_rst_n low, synchronous) empties the input queue and the held buffer.
// Top level of the fixed token substituter. Depends on fts_pkg, fts_front, fts_back.
module fixed_token_substituter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  logic       i_s_axis_tlast,   // end_of_text
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] char_out
    output logic       o_m_axis_tlast    // last_of_run
);

    fts_pkg::t_item  in_item;
    fts_pkg::t_qport q;
    logic            q_pop;

    assign in_item.ch  = i_s_axis_tdata;
    assign in_item.fin = i_s_axis_tlast;

    // Input accept and queue
    fts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_q     (q),
        .i_pop   (q_pop)
    );

    // Matching and emission
    fts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q       (q),
        .o_pop     (q_pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .o_m_last  (o_m_axis_tlast)
    );

endmodule

### bench/tb_escape_sb.sv
`timescale 1ns / 1ps
// Scoreboard for the token substituter bench: predicts the output text byte by byte.
// Depends on fts_pkg for the held buffer size and the token and match enums.
package tb_escape_pkg;

    // Upper bound on the bytes a single input item can produce
    localparam int MAX_RUN = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    class escape_scoreboard;
        // Source tokens and their escapes, ordered as t_tok
        string      token_text  [5] = '{"*", "infinity", "...", "{", "}"};
        string      escape_text [5] = '{"\\cout", "\\infty", "\\cdots", "\\{", "\\}"};
        logic [7:0] held [fts_pkg::MAX_TOKEN_LEN];
        int         held_cnt;
        t_out_char  expected_text [$];
        int         errors;

        function new();
            held_cnt = 0;
            errors   = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare the held bytes against the table; the head byte picks the token
        function fts_pkg::t_kind match_held(output fts_pkg::t_tok tok);
            string s;
            tok = fts_pkg::TOK_STAR;
            if (held_cnt == 0) return fts_pkg::KIND_NONE;
            for (int t = 0; t < 5; t++) begin
                s = token_text[t];
                if (s[0] != held[0]) continue;
                if (held_cnt > s.len()) return fts_pkg::KIND_NONE;
                for (int k = 1; k < held_cnt; k++)
                    if (s[k] != held[k]) return fts_pkg::KIND_NONE;
                tok = fts_pkg::t_tok'(t);
                return (held_cnt == s.len()) ? fts_pkg::KIND_FULL : fts_pkg::KIND_PREFIX;
            end
            return fts_pkg::KIND_NONE;
        endfunction

        function void put_char(ref t_out_char run[$], input logic [7:0] ch);
            t_out_char o;
            if (run.size() < MAX_RUN) begin
                o.ch   = ch;
                o.last = 1'b0;
                run.push_back(o);
            end
        endfunction

        // Pass the oldest held byte through raw and shift the rest down
        function void release_first(ref t_out_char run[$]);
            if (held_cnt == 0) return;
            put_char(run, held[0]);
            for (int k = 1; k < held_cnt; k++) held[k-1] = held[k];
            held_cnt--;
        endfunction

        // Accepted input item: work out the bytes it causes
        function void note_char(logic [7:0] ch, logic fin);
            t_out_char      run [$];
            fts_pkg::t_kind kind;
            fts_pkg::t_tok  tok;
            string          esc;
            if (held_cnt >= fts_pkg::MAX_TOKEN_LEN) release_first(run);
            held[held_cnt] = ch;
            held_cnt++;
            while (held_cnt > 0) begin
                kind = match_held(tok);
                if (kind == fts_pkg::KIND_FULL) begin
                    esc = escape_text[int'(tok)];
                    for (int k = 0; k < esc.len(); k++) put_char(run, esc[k]);
                    held_cnt = 0;
                end else if (kind == fts_pkg::KIND_PREFIX && !fin) begin
                    break;
                end else begin
                    release_first(run);
                end
            end
            if (run.size() > 0) run[run.size()-1].last = 1'b1;
            foreach (run[i]) expected_text.push_back(run[i]);
        endfunction

        // Accepted output item: compare with the oldest expected byte
        task check_char(logic [7:0] ch, logic last);
            t_out_char want;
            if (expected_text.size() == 0) begin
                report($sformatf("unexpected byte 0x%02h last=%0b", ch, last));
                return;
            end
            want = expected_text.pop_front();
            if (ch !== want.ch)
                report($sformatf("byte 0x%02h, wanted 0x%02h", ch, want.ch));
            if (last !== want.last)
                report($sformatf("last %0b, wanted %0b on byte 0x%02h",
                                 last, want.last, want.ch));
        endtask

        function int chars_owed();
            return expected_text.size();
        endfunction
    endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the token substituter bench: clock, reset, stream drivers, watchdog.
// Depends on fixed_token_substituter_core and the scoreboard in tb_escape_pkg.
module tb_top;

    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int WATCH_LIMIT  = 1000;

    logic       clk;
    logic       rst_n;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data;
    logic       s_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_data;
    logic       m_last;

    logic       quiet;
    int         hold_req;
    int         hold_done;
    int         items_sent;
    int         idle_cycles;

    tb_escape_pkg::escape_scoreboard sb = new();

    fixed_token_substituter_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // [7:0] char_in
        .i_s_axis_tlast  (s_last),    // end_of_text
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // [7:0] char_out
        .o_m_axis_tlast  (m_last)     // last_of_run
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one item and wait until it is taken
    task automatic send_item(input logic [7:0] ch, input logic fin);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            s_valid <= 1'b0;
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_data  <= ch;
        s_last  <= fin;
        do @(posedge clk); while (!s_ready);
        sb.note_char(ch, fin);
        items_sent++;
    endtask

    // Send a string; the end flag goes on its last byte only if asked
    task automatic send_text(input string s, input logic fin_at_end);
        for (int k = 0; k < s.len(); k++)
            send_item(s[k], fin_at_end && (k == s.len() - 1));
    endtask

    // Stop offering and wait for every expected byte
    task automatic wait_drained();
        @(negedge clk);
        s_valid <= 1'b0;
        while (sb.chars_owed() != 0) @(posedge clk);
    endtask

    // One random stretch of text, mostly shaped around the tokens
    task automatic send_segment();
        string heads;
        string mix;
        string tok;
        int    r;
        int    n;
        heads = "*i.{}";
        mix   = "*.i{}nfty";
        r     = $urandom_range(0, 99);
        if (r < 40) begin
            // whole token
            case ($urandom_range(0, 4))
                0:       tok = "*";
                1:       tok = "infinity";
                2:       tok = "...";
                3:       tok = "{";
                default: tok = "}";
            endcase
            for (int k = 0; k < tok.len(); k++)
                send_item(tok[k], $urandom_range(0, 15) == 0);
        end else if (r < 65) begin
            // token cut short by some other byte
            tok = ($urandom_range(0, 1) == 1) ? "infinity" : "...";
            n   = $urandom_range(1, tok.len() - 1);
            for (int k = 0; k < n; k++)
                send_item(tok[k], $urandom_range(0, 15) == 0);
            if ($urandom_range(0, 3) == 0)
                send_item(heads[$urandom_range(0, 4)], $urandom_range(0, 7) == 0);
            else
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else if (r < 85) begin
            // plain bytes
            n = $urandom_range(1, 4);
            repeat (n) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end else begin
            // token letters in random order
            n = $urandom_range(1, 6);
            repeat (n) send_item(mix[$urandom_range(0, 8)], $urandom_range(0, 15) == 0);
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int run_len;
        int stall_len;
        forever begin
            if (hold_req != hold_done) begin
                @(negedge clk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done++;
            end else begin
                run_len = $urandom_range(1, 24);
                repeat (run_len) begin
                    @(negedge clk);
                    m_ready <= 1'b1;
                end
                stall_len = pick_gap();
                if (stall_len > 0) begin
                    @(negedge clk);
                    m_ready <= 1'b0;
                    repeat (stall_len - 1) @(negedge clk);
                end
            end
        end
    end

    // Output monitor
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) sb.check_char(m_data, m_last);
    end

    // Watchdog: cycles with no item moving on either side
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence
    initial begin
        int  rand_start;
        bit  held_off;
        bit  paused;
        rst_n       = 1'b0;
        s_valid     = 1'b0;
        s_data      = 8'h00;
        s_last      = 1'b0;
        m_ready     = 1'b0;
        quiet       = 1'b0;
        hold_req    = 0;
        hold_done   = 0;
        items_sent  = 0;
        idle_cycles = 0;
        held_off    = 1'b0;
        paused      = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: every token, byte extremes, broken prefix with a token inside,
        // end flag on a plain byte, on a partial token and on a full token
        send_text("*{}...infinity", 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_text("..*", 1'b0);
        send_text("inf", 1'b1);
        send_item("{", 1'b1);

        // Random text
        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            quiet = ((items_sent - rand_start) >= 150 && (items_sent - rand_start) < 200)
                    || ((items_sent - rand_start) % 100 >= 80);
            if (!held_off && (items_sent - rand_start) >= 150) begin
                hold_req++;
                held_off = 1'b1;
            end
            if (!paused && (items_sent - rand_start) >= 260) begin
                wait_drained();
                paused = 1'b1;
            end
            send_segment();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
